// ----- rtl/jps_pkg.sv -----
// Shared types, codes and helpers for the jump point scan block.
package jps_pkg;

  // Signed grid coordinate: holds -1 .. 256 around an 8-bit map.
  typedef logic signed [9:0] coord_t;

  // Signed unit step on one axis: -1, 0 or +1.
  typedef logic signed [1:0] step_t;

  // Width of the configuration data word.
  localparam int CFG_W = 9;

  // Input operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;

  // Number of map cells read for one scan step.
  localparam int NUM_SLOTS = 5;

  // Read slots of one scan step: the cell itself and four neighbors.
  typedef enum logic [2:0] {
    SLOT_CUR,
    SLOT_N0,
    SLOT_N1,
    SLOT_N2,
    SLOT_N3
  } slot_t;

  // Updates of the scan position registers.
  typedef enum logic [2:0] {
    POS_HOLD,
    POS_STEP,
    POS_SUBX,
    POS_SUBY,
    POS_DIAG
  } pos_op_t;

  // Source of a result word.
  typedef enum logic [1:0] {
    RES_NONE,
    RES_SCAN,
    RES_MAIN
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_query;
    logic     wr_issue;
    logic     rd_issue;
    slot_t    rd_slot;
    logic     rd_diag;
    pos_op_t  pos_op;
    logic     res_load;
    res_sel_t res_sel;
  } jps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dir_zero;
    logic dir_diag;
    logic pipe_busy;
    logic cur_free;
    logic hit;
    logic forced;
  } jps_stat_t;

  // Sign of a minus b as a unit step.
  function automatic step_t sign_step(input logic [7:0] a, input logic [7:0] b);
    step_t s;
    if (a > b) begin
      s = 2'sd1;
    end else if (a < b) begin
      s = -2'sd1;
    end else begin
      s = 2'sd0;
    end
    return s;
  endfunction

endpackage

// ----- rtl/jump_point_scan.sv -----
// Top level of the jump point scan block: controller, datapath and checks.
//
//   channel   signals                                    handshake
//   command   start, operation, cell_*, parent_*,        start && !busy
//             target_*
//   result    done, found, jump_x, jump_y                done, one cycle
//   config    cfg_write, cfg_index, cfg_data             cfg_write
//
// A map write's result word is registered: done follows in the cycle after the write.
// For every visited cell of a query, sub-scan cells included, the five
// cell reads go into the map memory one a cycle and the three-stage
// read path drains before the step is judged. The result word comes in the
// cycle after the last step; a zero-direction query answers like a write.
// Reset clears control state only; the map is undefined until written.
// The receiver cannot stall: done is high for exactly one cycle per word.
module jump_point_scan
  import jps_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             operation,
  input  logic [7:0]       cell_x,
  input  logic [7:0]       cell_y,
  input  logic             cell_free,
  input  logic [7:0]       parent_x,
  input  logic [7:0]       parent_y,
  input  logic [7:0]       target_x,
  input  logic [7:0]       target_y,
  output logic             done,
  output logic             found,
  output logic [7:0]       jump_x,
  output logic [7:0]       jump_y,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  jps_cmd_t  cmd;
  jps_stat_t stat;

  jps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  jps_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .cell_free (cell_free),
    .parent_x  (parent_x),
    .parent_y  (parent_y),
    .target_x  (target_x),
    .target_y  (target_y),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .found     (found),
    .jump_x    (jump_x),
    .jump_y    (jump_y)
  );

`ifndef SYNTHESIS
  // A result word is only given once the block is free again.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result word while busy");

  // A map write answers in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_WRITE) |=> done)
    else $error("write result missing");

  // A word without a jump point carries zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (jump_x == 8'd0 && jump_y == 8'd0))
    else $error("not-found word with coordinates");

  // The block only becomes busy by accepting a query.
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && operation == OP_QUERY))
    else $error("busy without a query");
`endif

endmodule

// ----- rtl/jps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module jps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/jps_ctrl.sv -----
// Controller state machine that sequences map reads and scan phases.
module jps_ctrl
  import jps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      operation,
  input  jps_stat_t stat,
  output jps_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  // Scan phase: plain straight scan, diagonal walk, or one of its sub-scans.
  typedef enum logic [1:0] {
    PH_LINE,
    PH_DIAG,
    PH_SUBX,
    PH_SUBY
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;
  slot_t  slot, slot_next;

  function automatic slot_t next_slot(input slot_t s);
    slot_t n;
    unique case (s)
      SLOT_CUR: n = SLOT_N0;
      SLOT_N0:  n = SLOT_N1;
      SLOT_N1:  n = SLOT_N2;
      SLOT_N2:  n = SLOT_N3;
      default:  n = SLOT_CUR;
    endcase
    return n;
  endfunction

  // Next state and commands.
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    slot_next      = slot;
    cmd.load_query = 1'b0;
    cmd.wr_issue   = 1'b0;
    cmd.rd_issue   = 1'b0;
    cmd.rd_slot    = slot;
    cmd.rd_diag    = (phase == PH_DIAG);
    cmd.pos_op     = POS_HOLD;
    cmd.res_load   = 1'b0;
    cmd.res_sel    = RES_NONE;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_WRITE) begin
            cmd.wr_issue = 1'b1;
            cmd.res_load = 1'b1;
          end else if (stat.dir_zero) begin
            cmd.res_load = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            phase_next     = stat.dir_diag ? PH_DIAG : PH_LINE;
            slot_next      = SLOT_CUR;
            state_next     = ST_ISSUE;
          end
        end
      end

      ST_ISSUE: begin
        cmd.rd_issue = 1'b1;
        if (slot == SLOT_N3) begin
          state_next = ST_WAIT;
        end else begin
          slot_next = next_slot(slot);
        end
      end

      ST_WAIT: begin
        // All five cells of the step are in once the read path drains.
        if (!stat.pipe_busy) begin
          state_next = ST_ISSUE;
          slot_next  = SLOT_CUR;
          unique case (phase)
            PH_LINE: begin
              if (!stat.cur_free) begin
                cmd.res_load = 1'b1;
                state_next   = ST_IDLE;
              end else if (stat.hit || stat.forced) begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_SCAN;
                state_next   = ST_IDLE;
              end else begin
                cmd.pos_op = POS_STEP;
              end
            end
            PH_DIAG: begin
              if (!stat.cur_free) begin
                cmd.res_load = 1'b1;
                state_next   = ST_IDLE;
              end else if (stat.hit || stat.forced) begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_MAIN;
                state_next   = ST_IDLE;
              end else begin
                cmd.pos_op = POS_SUBX;
                phase_next = PH_SUBX;
              end
            end
            PH_SUBX: begin
              if (!stat.cur_free) begin
                cmd.pos_op = POS_SUBY;
                phase_next = PH_SUBY;
              end else if (stat.hit || stat.forced) begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_MAIN;
                state_next   = ST_IDLE;
              end else begin
                cmd.pos_op = POS_STEP;
              end
            end
            default: begin
              // Vertical sub-scan ran out: take the next diagonal step.
              if (!stat.cur_free) begin
                cmd.pos_op = POS_DIAG;
                phase_next = PH_DIAG;
              end else if (stat.hit || stat.forced) begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_MAIN;
                state_next   = ST_IDLE;
              end else begin
                cmd.pos_op = POS_STEP;
              end
            end
          endcase
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and registered busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_LINE;
      slot  <= SLOT_CUR;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      slot  <= slot_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

// ----- rtl/jps_dpath.sv -----
// Datapath: map storage, read pipeline, scan positions and result registers.
module jps_dpath
  import jps_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic [7:0]       cell_x,
  input  logic [7:0]       cell_y,
  input  logic             cell_free,
  input  logic [7:0]       parent_x,
  input  logic [7:0]       parent_y,
  input  logic [7:0]       target_x,
  input  logic [7:0]       target_y,
  input  jps_cmd_t         cmd,
  output jps_stat_t        stat,
  output logic             done,
  output logic             found,
  output logic [7:0]       jump_x,
  output logic [7:0]       jump_y
);

  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COL_CAP = (MAX_COLS < 256) ? MAX_COLS : 256;
  localparam int ROW_CAP = (MAX_ROWS < 256) ? MAX_ROWS : 256;

  logic [CFG_W-1:0] map_width, map_height;
  logic [CFG_W-1:0] cols_used, rows_used;

  coord_t m_x, m_y, s_x, s_y;
  step_t  d_x, d_y, sd_x, sd_y;
  logic [7:0] t_x, t_y;
  step_t  in_dx, in_dy;

  step_t  p_x, p_y, o_x, o_y;
  coord_t rd_x, rd_y;
  logic   rd_in;
  logic   wr_in;

  logic        p1_vld, p1_wr, p1_in, p1_wdata;
  logic [7:0]  p1_col, p1_row;
  slot_t       p1_slot;
  logic        p2_vld, p2_in;
  slot_t       p2_slot;
  logic [ADDR_W-1:0] ram_addr;
  logic        ram_we;
  logic [0:0]  ram_rdata;
  logic [NUM_SLOTS-1:0] free_bits;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= 9'd256;
      map_height <= 9'd256;
    end else if (cfg_write) begin
      if (cfg_index == CFG_MAP_WIDTH) begin
        map_width <= cfg_data;
      end else begin
        map_height <= cfg_data;
      end
    end
  end

  // Sizes in use, limited by the storage.
  assign cols_used = (map_width > CFG_W'(COL_CAP)) ? CFG_W'(COL_CAP) : map_width;
  assign rows_used = (map_height > CFG_W'(ROW_CAP)) ? CFG_W'(ROW_CAP) : map_height;

  // Query direction from the neighbor and parent cells.
  assign in_dx = sign_step(cell_x, parent_x);
  assign in_dy = sign_step(cell_y, parent_y);

  // Scan position registers.
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      m_x  <= coord_t'({2'b00, cell_x});
      m_y  <= coord_t'({2'b00, cell_y});
      s_x  <= coord_t'({2'b00, cell_x});
      s_y  <= coord_t'({2'b00, cell_y});
      d_x  <= in_dx;
      d_y  <= in_dy;
      sd_x <= in_dx;
      sd_y <= in_dy;
      t_x  <= target_x;
      t_y  <= target_y;
    end else begin
      unique case (cmd.pos_op)
        POS_STEP: begin
          s_x <= s_x + coord_t'(sd_x);
          s_y <= s_y + coord_t'(sd_y);
        end
        POS_SUBX: begin
          s_x  <= m_x;
          s_y  <= m_y;
          sd_x <= d_x;
          sd_y <= 2'sd0;
        end
        POS_SUBY: begin
          s_x  <= m_x;
          s_y  <= m_y;
          sd_x <= 2'sd0;
          sd_y <= d_y;
        end
        POS_DIAG: begin
          m_x <= m_x + coord_t'(d_x);
          m_y <= m_y + coord_t'(d_y);
          s_x <= m_x + coord_t'(d_x);
          s_y <= m_y + coord_t'(d_y);
        end
        default: begin
        end
      endcase
    end
  end

  // Read offset of the slot. Straight scans look at the cells beside the
  // scan cell and one step ahead of them; diagonal scans look behind.
  always_comb begin
    if (sd_x != 2'sd0) begin
      p_x = 2'sd0;
      p_y = 2'sd1;
    end else begin
      p_x = 2'sd1;
      p_y = 2'sd0;
    end
    o_x = 2'sd0;
    o_y = 2'sd0;
    unique case (cmd.rd_slot)
      SLOT_N0: begin
        o_x = cmd.rd_diag ? 2'sd0 : -p_x;
        o_y = cmd.rd_diag ? -d_y  : -p_y;
      end
      SLOT_N1: begin
        o_x = cmd.rd_diag ? d_x  : step_t'(sd_x - p_x);
        o_y = cmd.rd_diag ? -d_y : step_t'(sd_y - p_y);
      end
      SLOT_N2: begin
        o_x = cmd.rd_diag ? -d_x  : p_x;
        o_y = cmd.rd_diag ? 2'sd0 : p_y;
      end
      SLOT_N3: begin
        o_x = cmd.rd_diag ? -d_x : step_t'(sd_x + p_x);
        o_y = cmd.rd_diag ? d_y  : step_t'(sd_y + p_y);
      end
      default: begin
      end
    endcase
  end

  assign rd_x  = s_x + coord_t'(o_x);
  assign rd_y  = s_y + coord_t'(o_y);
  assign rd_in = !rd_x[9] && (rd_x[8:0] < cols_used) &&
                 !rd_y[9] && (rd_y[8:0] < rows_used);
  assign wr_in = (32'(cell_x) < 32'(MAX_COLS)) && (32'(cell_y) < 32'(MAX_ROWS));

  // Read path stage one: cell coordinates and range check.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= cmd.wr_issue || cmd.rd_issue;
    end
    if (cmd.wr_issue) begin
      p1_wr    <= 1'b1;
      p1_col   <= cell_x;
      p1_row   <= cell_y;
      p1_in    <= wr_in;
      p1_wdata <= cell_free;
      p1_slot  <= SLOT_CUR;
    end else begin
      p1_wr    <= 1'b0;
      p1_col   <= rd_x[7:0];
      p1_row   <= rd_y[7:0];
      p1_in    <= rd_in;
      p1_wdata <= 1'b0;
      p1_slot  <= cmd.rd_slot;
    end
  end

  // Stage two: linear address into the map memory.
  assign ram_addr = ADDR_W'(p1_row) * ADDR_W'(MAX_COLS) + ADDR_W'(p1_col);
  assign ram_we   = p1_vld && p1_wr && p1_in;

  jps_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (p1_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld && !p1_wr;
    end
    p2_in   <= p1_in;
    p2_slot <= p1_slot;
  end

  // Stage three: cells off the map read as blocked.
  always_ff @(posedge clk) begin
    if (p2_vld) begin
      free_bits[p2_slot] <= ram_rdata[0] && p2_in;
    end
  end

  // Status to the controller.
  assign stat.dir_zero  = (in_dx == 2'sd0) && (in_dy == 2'sd0);
  assign stat.dir_diag  = (in_dx != 2'sd0) && (in_dy != 2'sd0);
  assign stat.pipe_busy = p1_vld || p2_vld;
  assign stat.cur_free  = free_bits[SLOT_CUR];
  assign stat.hit       = (s_x == coord_t'({2'b00, t_x})) && (s_y == coord_t'({2'b00, t_y}));
  assign stat.forced    = (!free_bits[SLOT_N0] && free_bits[SLOT_N1]) ||
                          (!free_bits[SLOT_N2] && free_bits[SLOT_N3]);

  // Result word and its strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_load;
    end
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_SCAN: begin
          found  <= 1'b1;
          jump_x <= s_x[7:0];
          jump_y <= s_y[7:0];
        end
        RES_MAIN: begin
          found  <= 1'b1;
          jump_x <= m_x[7:0];
          jump_y <= m_y[7:0];
        end
        default: begin
          found  <= 1'b0;
          jump_x <= 8'd0;
          jump_y <= 8'd0;
        end
      endcase
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the jump point scan block with map writes and scan queries.
module tb_top
  import jps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One command word as sent to the block.
  typedef struct {
    logic       op;
    logic [7:0] cx;
    logic [7:0] cy;
    logic       cf;
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] tx;
    logic [7:0] ty;
    bit         drain;
  } scan_cmd_t;

  // One result word: whether a jump point exists and where.
  typedef struct packed {
    logic       found;
    logic [7:0] x;
    logic [7:0] y;
  } jump_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic operation = OP_WRITE;
  logic [7:0] cell_x = '0;
  logic [7:0] cell_y = '0;
  logic cell_free = 1'b0;
  logic [7:0] parent_x = '0;
  logic [7:0] parent_y = '0;
  logic [7:0] target_x = '0;
  logic [7:0] target_y = '0;
  logic done;
  logic found;
  logic [7:0] jump_x;
  logic [7:0] jump_y;
  logic cfg_write = 1'b0;
  logic cfg_index = CFG_MAP_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  // Commands waiting to be sent, and answers waiting for their result word.
  scan_cmd_t cmd_q[$];
  scan_cmd_t cur_cmd;
  jump_answer_t expected_jumps[$];
  jump_answer_t seen_want;

  // Our own copy of the map and of the sizes in use.
  bit free_map [0:65535];
  bit cell_loaded [0:65535];
  int cols_used = 256;
  int rows_used = 256;

  int sender_idle_pct = 0;
  int mismatch_count = 0;

  jump_point_scan DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .cell_x(cell_x),
    .cell_y(cell_y),
    .cell_free(cell_free),
    .parent_x(parent_x),
    .parent_y(parent_y),
    .target_x(target_x),
    .target_y(target_y),
    .done(done),
    .found(found),
    .jump_x(jump_x),
    .jump_y(jump_y),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A cell is open only inside the map in use and when marked free.
  function automatic bit cell_open(input int x, input int y);
    if (x < 0 || x >= cols_used || y < 0 || y >= rows_used) return 1'b0;
    return free_map[y * 256 + x];
  endfunction

  // Forced neighbor test for a straight move.
  function automatic bit line_forced(input int x, input int y, input int dx, input int dy);
    if (dx != 0) begin
      return (!cell_open(x, y - 1) && cell_open(x + dx, y - 1)) ||
             (!cell_open(x, y + 1) && cell_open(x + dx, y + 1));
    end
    return (!cell_open(x - 1, y) && cell_open(x - 1, y + dy)) ||
           (!cell_open(x + 1, y) && cell_open(x + 1, y + dy));
  endfunction

  // Forced neighbor test for a diagonal move.
  function automatic bit diag_forced(input int x, input int y, input int dx, input int dy);
    return (!cell_open(x, y - dy) && cell_open(x + dx, y - dy)) ||
           (!cell_open(x - dx, y) && cell_open(x - dx, y + dy));
  endfunction

  // Walk a straight line until the target, a forced cell, or a wall.
  function automatic bit line_walk(input int x0, input int y0, input int dx, input int dy,
                                   input int tx, input int ty, output int jx, output int jy);
    int x;
    int y;
    x = x0;
    y = y0;
    jx = 0;
    jy = 0;
    while (cell_open(x, y)) begin
      if ((x == tx && y == ty) || line_forced(x, y, dx, dy)) begin
        jx = x;
        jy = y;
        return 1'b1;
      end
      x += dx;
      y += dy;
    end
    return 1'b0;
  endfunction

  // Walk a diagonal; each cell also launches straight walks along both axes.
  function automatic bit diag_walk(input int x0, input int y0, input int dx, input int dy,
                                   input int tx, input int ty, output int jx, output int jy);
    int x;
    int y;
    int sx;
    int sy;
    x = x0;
    y = y0;
    jx = 0;
    jy = 0;
    while (cell_open(x, y)) begin
      if ((x == tx && y == ty) || diag_forced(x, y, dx, dy) ||
          line_walk(x, y, dx, 0, tx, ty, sx, sy) ||
          line_walk(x, y, 0, dy, tx, ty, sx, sy)) begin
        jx = x;
        jy = y;
        return 1'b1;
      end
      x += dx;
      y += dy;
    end
    return 1'b0;
  endfunction

  // Apply one command to our map copy and work out its result word.
  function automatic jump_answer_t predict_jump(input scan_cmd_t c);
    jump_answer_t r;
    int dx;
    int dy;
    int jx;
    int jy;
    r = '0;
    jx = 0;
    jy = 0;
    if (c.op == OP_WRITE) begin
      free_map[{c.cy, c.cx}] = c.cf;
      return r;
    end
    dx = (c.cx > c.px) ? 1 : ((c.cx < c.px) ? -1 : 0);
    dy = (c.cy > c.py) ? 1 : ((c.cy < c.py) ? -1 : 0);
    if (dx != 0 && dy != 0) begin
      r.found = diag_walk(c.cx, c.cy, dx, dy, c.tx, c.ty, jx, jy);
    end else if (dx != 0 || dy != 0) begin
      r.found = line_walk(c.cx, c.cy, dx, dy, c.tx, c.ty, jx, jy);
    end
    if (r.found) begin
      r.x = jx[7:0];
      r.y = jy[7:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Driver: present the next command word once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_jumps.insert(expected_jumps.size(), predict_jump(cur_cmd));
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct &&
            !(cmd_q[0].drain && expected_jumps.size() != 0)) begin
          cur_cmd = cmd_q.pop_front();
          start <= 1'b1;
          operation <= cur_cmd.op;
          cell_x <= cur_cmd.cx;
          cell_y <= cur_cmd.cy;
          cell_free <= cur_cmd.cf;
          parent_x <= cur_cmd.px;
          parent_y <= cur_cmd.py;
          target_x <= cur_cmd.tx;
          target_y <= cur_cmd.ty;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result word is matched against the oldest answer.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_jumps.size() == 0) begin
        report_mismatch("result word with nothing outstanding");
      end else begin
        seen_want = expected_jumps.pop_front();
        check_field("found", {7'b0, found}, {7'b0, seen_want.found});
        check_field("jump_x", jump_x, seen_want.x);
        check_field("jump_y", jump_y, seen_want.y);
      end
    end
  end

  task automatic push_cmd(input logic op, input int cx, input int cy, input int cf,
                          input int px, input int py, input int tx, input int ty,
                          input bit drain);
    scan_cmd_t c;
    c.op = op;
    c.cx = cx[7:0];
    c.cy = cy[7:0];
    c.cf = cf[0];
    c.px = px[7:0];
    c.py = py[7:0];
    c.tx = tx[7:0];
    c.ty = ty[7:0];
    c.drain = drain;
    if (op == OP_WRITE) cell_loaded[{c.cy, c.cx}] = 1'b1;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  task automatic push_write(input int x, input int y, input int cf);
    push_cmd(OP_WRITE, x, y, cf, $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
  endtask

  // Pick a parent on the far side of c so that the direction comes out as d.
  function automatic int aim_parent(input int c, input int d);
    if (d > 0 && c > 0) return $urandom_range(0, 1) ? c - 1 : $urandom_range(0, c - 1);
    if (d < 0 && c < 255) return $urandom_range(0, 1) ? c + 1 : $urandom_range(c + 1, 255);
    return c;
  endfunction

  // Mostly well-formed queries from a map cell; some fully random ones.
  task automatic push_random_query();
    int cx;
    int cy;
    int dx;
    int dy;
    int tx;
    int ty;
    int k;
    bit drain;
    drain = ($urandom_range(0, 49) == 0);
    if (cols_used == 0 || rows_used == 0 || $urandom_range(0, 9) == 0) begin
      push_cmd(OP_QUERY, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
               $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), drain);
      return;
    end
    cx = $urandom_range(0, cols_used - 1);
    cy = $urandom_range(0, rows_used - 1);
    dx = $urandom_range(0, 2) - 1;
    dy = $urandom_range(0, 2) - 1;
    case ($urandom_range(0, 3))
      0, 1: begin
        tx = $urandom_range(0, cols_used - 1);
        ty = $urandom_range(0, rows_used - 1);
      end
      2: begin
        // Target placed on the scan ray.
        k = $urandom_range(0, 12);
        tx = cx + k * dx;
        ty = cy + k * dy;
        if (tx < 0 || tx > 255 || ty < 0 || ty > 255) begin
          tx = cx;
          ty = cy;
        end
      end
      default: begin
        tx = $urandom_range(0, 255);
        ty = $urandom_range(0, 255);
      end
    endcase
    push_cmd(OP_QUERY, cx, cy, $urandom_range(0, 1), aim_parent(cx, dx), aim_parent(cy, dy),
             tx, ty, drain);
  endtask

  // Wait until every command is taken and every result word has come.
  task automatic wait_drained();
    do @(negedge clk); while (cmd_q.size() != 0 || start || expected_jumps.size() != 0);
  endtask

  // Write both size registers on back-to-back cycles.
  task automatic set_map_size(input int w, input int h);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_data <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_data <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    cols_used = (w > 256) ? 256 : w;
    rows_used = (h > 256) ? 256 : h;
  endtask

  // One setting: resize, write every map cell in use never loaded and some others, then random queries.
  task automatic run_phase(input int w, input int h, input int queries,
                           input int idle_pct, input int free_pct);
    wait_drained();
    repeat (4) @(posedge clk);
    set_map_size(w, h);
    @(negedge clk);
    sender_idle_pct = idle_pct;
    for (int y = 0; y < rows_used; y++) begin
      for (int x = 0; x < cols_used; x++) begin
        if (!cell_loaded[y * 256 + x] || $urandom_range(0, 7) == 0) begin
          push_write(x, y, $urandom_range(0, 99) < free_pct);
        end
      end
    end
    repeat (queries) push_random_query();
  endtask

  // Main sequence: directed checks on a 3x3 map, then randomized settings.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_map_size(3, 3);
    @(negedge clk);
    // Ring of free cells around a blocked center.
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        push_cmd(OP_WRITE, x, y, !(x == 1 && y == 1), 0, 0, 0, 0, 1'b0);
      end
    end
    push_cmd(OP_WRITE, 255, 255, 1, 255, 255, 255, 255, 1'b0);
    // Zero direction, start off the map, start blocked.
    push_cmd(OP_QUERY, 0, 0, 0, 0, 0, 2, 2, 1'b1);
    push_cmd(OP_QUERY, 5, 5, 0, 4, 4, 0, 0, 1'b0);
    push_cmd(OP_QUERY, 1, 1, 0, 0, 1, 2, 1, 1'b0);
    // Straight scans: forced neighbor, toward column 0, target at the start.
    push_cmd(OP_QUERY, 1, 0, 1, 0, 0, 255, 255, 1'b0);
    push_cmd(OP_QUERY, 2, 0, 0, 255, 0, 200, 200, 1'b0);
    push_cmd(OP_QUERY, 0, 2, 1, 0, 0, 0, 2, 1'b0);
    push_cmd(OP_QUERY, 2, 2, 0, 2, 255, 2, 0, 1'b0);
    // Diagonal scans: off the far edge, past row and column 0, sub-scan hit.
    push_cmd(OP_QUERY, 2, 2, 1, 1, 1, 0, 0, 1'b0);
    push_cmd(OP_QUERY, 0, 0, 0, 255, 255, 9, 9, 1'b0);
    push_cmd(OP_QUERY, 2, 2, 1, 255, 255, 0, 0, 1'b0);
    push_cmd(OP_QUERY, 255, 255, 1, 0, 0, 255, 255, 1'b0);

    run_phase(8, 8, 110, 0, 75);
    run_phase(256, 1, 90, 77, 85);
    run_phase(1, 256, 90, 17, 85);
    run_phase(0, 7, 30, 0, 70);
    run_phase(9, 0, 30, 77, 70);
    run_phase(16, 16, 150, 0, 65);
    run_phase(1, 1, 25, 17, 70);
    run_phase(511, 1, 80, 0, 80);
    run_phase(1, 300, 80, 77, 80);
    run_phase(12, 6, 150, 17, 75);
    run_phase(5, 16, 100, 0, 70);

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog for a block that stops answering.
  initial begin
    #100ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
